[rtl/cfpr_pkg.sv]
// Shared constants and types for the framed packet receiver.
package cfpr_pkg;

  localparam int BUF_DEPTH_DEF = 64;

  localparam int BYTE_W  = 8;
  localparam int CRC_W   = 16;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 7;
  localparam int IDX_W   = 2;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

  localparam logic [BYTE_W-1:0] ADDR_RESET   = 8'hA1;
  localparam logic [BYTE_W-1:0] OPTION_RESET = 8'h66;
  localparam logic              CHECK_RESET  = 1'b1;

  localparam logic [IDX_W-1:0] REG_STATION = 2'd0;
  localparam logic [IDX_W-1:0] REG_OPTION  = 2'd1;
  localparam logic [IDX_W-1:0] REG_CHECK   = 2'd2;

  localparam logic [STAT_W-1:0] ST_DATA     = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] ST_CRCERR   = 2'd2;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd3;

  typedef enum logic [3:0] {
    PH_HUNT   = 4'b0001,
    PH_OPTION = 4'b0010,
    PH_LENGTH = 4'b0100,
    PH_BODY   = 4'b1000
  } phase_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CRC   = 6'b000010,
    S_CHECK = 6'b000100,
    S_ONE   = 6'b001000,
    S_READ  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

endpackage

[rtl/cfpr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module cfpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/crc16_framed_packet_receiver_top.sv]
// Top level of the framed packet receiver with Modbus CRC-16 check.
//
// Input channel (in_valid / in_ready / rx_byte) takes one received word at a
// time. A frame is the station address, the option byte, a nonzero length
// and that many body words. With checking on, the last two body words are a
// Modbus CRC-16, low byte first, over header and payload.
// Output channel (out_valid / out_ready / status, payload_byte, last,
// payload_count) gives the payload words of a good frame with last on the
// final one, or one empty-frame, checksum-error or overflow word.
// Configuration: cfg_write / cfg_index / cfg_data, written while idle.
// Timing: the CRC is updated one bit per cycle, and no input word is taken
// while a word is being folded into it; each body word folds in the word
// two places before it, so the first two body words fold in none. Payload
// words are read from the body buffer, a registered read, one at a time,
// each passing a read state and an emit state before it enters the output
// register.
// Reset: registers return to their defaults, the receiver hunts for an
// address and the output register is empty. When the receiver downstream
// stalls, the output register holds its word and no further input word is
// taken until the last result of the frame has entered the output register.
module crc16_framed_packet_receiver_top #(
  parameter int BUF_DEPTH = cfpr_pkg::BUF_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [cfpr_pkg::IDX_W-1:0]   cfg_index,
  input  logic [cfpr_pkg::BYTE_W-1:0]  cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [cfpr_pkg::BYTE_W-1:0]  rx_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [cfpr_pkg::STAT_W-1:0]  status,
  output logic [cfpr_pkg::BYTE_W-1:0]  payload_byte,
  output logic                         last,
  output logic [cfpr_pkg::COUNT_W-1:0] payload_count
);

  // Body counter holds values up to the depth itself; address indexes only.
  localparam int CNT_W = $clog2(BUF_DEPTH + 1);
  localparam int AW    = $clog2(BUF_DEPTH);

  // Configuration registers
  logic [cfpr_pkg::BYTE_W-1:0] station_address;
  logic [cfpr_pkg::BYTE_W-1:0] option_byte;
  logic                        check_enable;

  // Frame state
  cfpr_pkg::state_t            state;
  cfpr_pkg::phase_t            phase;
  logic [cfpr_pkg::BYTE_W-1:0] declared_length;
  logic [CNT_W-1:0]            body_count;
  logic [cfpr_pkg::CRC_W-1:0]  crc;
  logic [cfpr_pkg::BYTE_W-1:0] crc_data;
  logic [2:0]                  bit_cnt;
  logic                        check_after;
  // Last two body words: the CRC trails the body by two words, and at the
  // end of a frame these two are the received checksum.
  logic [cfpr_pkg::BYTE_W-1:0] hist1;
  logic [cfpr_pkg::BYTE_W-1:0] hist2;
  logic [cfpr_pkg::STAT_W-1:0] res_status;
  logic [CNT_W-1:0]            emit_len;
  logic [AW-1:0]               rd_idx;

  logic                        accept;
  logic                        slot_free;
  logic                        out_load;
  logic                        crc_fb;
  logic [cfpr_pkg::CRC_W-1:0]  crc_step;
  logic                        overflow;
  logic                        ram_we;
  logic [cfpr_pkg::BYTE_W-1:0] ram_rdata;
  logic [cfpr_pkg::CRC_W-1:0]  rx_crc;
  logic [CNT_W-1:0]            len_trunc;
  logic                        emit_last;

  assign in_ready  = (state == cfpr_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign out_load  = slot_free && (state == cfpr_pkg::S_ONE || state == cfpr_pkg::S_EMIT);

  // One bit of the reflected CRC per cycle, data LSB first.
  assign crc_fb   = crc[0] ^ crc_data[0];
  assign crc_step = {1'b0, crc[cfpr_pkg::CRC_W-1:1]}
                    ^ (crc_fb ? cfpr_pkg::CRC_POLY : '0);

  assign overflow  = (body_count >= CNT_W'(BUF_DEPTH));
  assign ram_we    = accept && (phase == cfpr_pkg::PH_BODY) && !overflow;
  assign rx_crc    = {hist1, hist2};
  assign len_trunc = CNT_W'(declared_length);
  assign emit_last = ((CNT_W'(rd_idx) + CNT_W'(1)) == emit_len);

  cfpr_ram #(
    .WIDTH (cfpr_pkg::BYTE_W),
    .DEPTH (BUF_DEPTH)
  ) u_body_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (body_count[AW-1:0]),
    .wdata (rx_byte),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // Configuration port; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      station_address <= cfpr_pkg::ADDR_RESET;
      option_byte     <= cfpr_pkg::OPTION_RESET;
      check_enable    <= cfpr_pkg::CHECK_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        cfpr_pkg::REG_STATION: station_address <= cfg_data;
        cfpr_pkg::REG_OPTION:  option_byte     <= cfg_data;
        cfpr_pkg::REG_CHECK:   check_enable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Frame sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= cfpr_pkg::S_IDLE;
      phase           <= cfpr_pkg::PH_HUNT;
      declared_length <= '0;
      body_count      <= '0;
      crc             <= cfpr_pkg::CRC_INIT;
      bit_cnt         <= '0;
      check_after     <= 1'b0;
      rd_idx          <= '0;
      out_valid       <= 1'b0;
    end else begin
      // Load a fresh word or drop the one just taken.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        cfpr_pkg::S_IDLE: begin
          if (accept) begin
            bit_cnt <= '0;
            case (phase)
              cfpr_pkg::PH_HUNT: begin
                if (rx_byte == station_address) begin
                  body_count  <= '0;
                  crc         <= cfpr_pkg::CRC_INIT;
                  crc_data    <= rx_byte;
                  phase       <= cfpr_pkg::PH_OPTION;
                  check_after <= 1'b0;
                  state       <= cfpr_pkg::S_CRC;
                end
              end
              cfpr_pkg::PH_OPTION: begin
                if (rx_byte == option_byte) begin
                  crc_data    <= rx_byte;
                  phase       <= cfpr_pkg::PH_LENGTH;
                  check_after <= 1'b0;
                  state       <= cfpr_pkg::S_CRC;
                end else begin
                  phase      <= cfpr_pkg::PH_HUNT;
                  body_count <= '0;
                  crc        <= cfpr_pkg::CRC_INIT;
                end
              end
              cfpr_pkg::PH_LENGTH: begin
                if (rx_byte != '0) begin
                  declared_length <= rx_byte;
                  crc_data        <= rx_byte;
                  phase           <= cfpr_pkg::PH_BODY;
                  check_after     <= 1'b0;
                  state           <= cfpr_pkg::S_CRC;
                end else begin
                  phase      <= cfpr_pkg::PH_HUNT;
                  body_count <= '0;
                  crc        <= cfpr_pkg::CRC_INIT;
                end
              end
              cfpr_pkg::PH_BODY: begin
                if (overflow) begin
                  // Buffer full: drop the frame and report it.
                  phase      <= cfpr_pkg::PH_HUNT;
                  body_count <= '0;
                  crc        <= cfpr_pkg::CRC_INIT;
                  res_status <= cfpr_pkg::ST_OVERFLOW;
                  state      <= cfpr_pkg::S_ONE;
                end else begin
                  hist1      <= rx_byte;
                  hist2      <= hist1;
                  body_count <= body_count + CNT_W'(1);
                  crc_data   <= hist2;
                  if (body_count >= CNT_W'(2)) begin
                    check_after <= 1'b1;
                    state       <= cfpr_pkg::S_CRC;
                  end else begin
                    state <= cfpr_pkg::S_CHECK;
                  end
                end
              end
              default: phase <= cfpr_pkg::PH_HUNT;
            endcase
          end
        end
        cfpr_pkg::S_CRC: begin
          crc      <= crc_step;
          crc_data <= {1'b0, crc_data[cfpr_pkg::BYTE_W-1:1]};
          bit_cnt  <= bit_cnt + 3'd1;
          if (bit_cnt == 3'd7) begin
            state <= check_after ? cfpr_pkg::S_CHECK : cfpr_pkg::S_IDLE;
          end
        end
        cfpr_pkg::S_CHECK: begin
          if (8'(body_count) < declared_length) begin
            state <= cfpr_pkg::S_IDLE;
          end else begin
            // Frame complete: back to hunting, then decide the outcome.
            phase      <= cfpr_pkg::PH_HUNT;
            body_count <= '0;
            crc        <= cfpr_pkg::CRC_INIT;
            rd_idx     <= '0;
            if (check_enable && (declared_length < 8'd2 || rx_crc != crc)) begin
              res_status <= cfpr_pkg::ST_CRCERR;
              state      <= cfpr_pkg::S_ONE;
            end else if (check_enable && declared_length == 8'd2) begin
              res_status <= cfpr_pkg::ST_EMPTY;
              state      <= cfpr_pkg::S_ONE;
            end else begin
              emit_len <= check_enable ? (len_trunc - CNT_W'(2)) : len_trunc;
              state    <= cfpr_pkg::S_READ;
            end
          end
        end
        cfpr_pkg::S_ONE: begin
          if (slot_free) begin
            status        <= res_status;
            payload_byte  <= '0;
            last          <= 1'b1;
            payload_count <= '0;
            state         <= cfpr_pkg::S_IDLE;
          end
        end
        cfpr_pkg::S_READ: begin
          state <= cfpr_pkg::S_EMIT;
        end
        cfpr_pkg::S_EMIT: begin
          // Hold the read address until the output register can take the word.
          if (slot_free) begin
            status        <= cfpr_pkg::ST_DATA;
            payload_byte  <= ram_rdata;
            last          <= emit_last;
            payload_count <= cfpr_pkg::COUNT_W'(emit_len);
            if (emit_last) begin
              state <= cfpr_pkg::S_IDLE;
            end else begin
              rd_idx <= rd_idx + AW'(1);
              state  <= cfpr_pkg::S_READ;
            end
          end
        end
        default: state <= cfpr_pkg::S_IDLE;
      endcase
    end
  end

endmodule
